### hw/rtl/gsr_pkg.sv
package gsr_pkg;

    localparam int GlyphBits = 15;
    localparam int XW = 10;
    localparam int YW = 9;
    localparam int ColorW = 16;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    localparam logic [GlyphBits-1:0] GLYPH_ROM [12] = '{
        15'h7B6F, 15'h2C97, 15'h73E7, 15'h73CF, 15'h5BC9, 15'h79CF,
        15'h79EF, 15'h7292, 15'h7BEF, 15'h7BCF, 15'h0410, 15'h01C0
    };

    typedef struct packed {
        logic [GlyphBits-1:0] bits;
        logic [XW-1:0]        base_x;
        logic [YW-1:0]        base_y;
        logic [ColorW-1:0]    color;
    } t_work;

    typedef struct packed {
        logic [XW-1:0]     x;
        logic [YW-1:0]     y;
        logic [ColorW-1:0] color;
        logic              last;
    } t_pixel;

    // glyph word for a character, zero for anything that does not draw
    function automatic logic [GlyphBits-1:0] glyph_bits(input logic [7:0] code);
        logic [GlyphBits-1:0] g;
        logic [7:0]           ofs;
        ofs = code - CHAR_ZERO;
        case (code) inside
            [CHAR_ZERO:CHAR_NINE]: g = GLYPH_ROM[ofs[3:0]];
            CHAR_COLON:            g = GLYPH_ROM[10];
            CHAR_HYPHEN:           g = GLYPH_ROM[11];
            default:               g = '0;
        endcase
        return g;
    endfunction

    // bit 14 is the top-left cell, scan runs row by row
    function automatic logic [2:0] cell_row(input logic [3:0] bit_idx);
        logic [2:0] r;
        case (bit_idx) inside
            4'd14, 4'd13, 4'd12: r = 3'd0;
            4'd11, 4'd10, 4'd9:  r = 3'd1;
            4'd8, 4'd7, 4'd6:    r = 3'd2;
            4'd5, 4'd4, 4'd3:    r = 3'd3;
            default:             r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cell_col(input logic [3:0] bit_idx);
        logic [1:0] c;
        case (bit_idx) inside
            4'd14, 4'd11, 4'd8, 4'd5, 4'd2: c = 2'd0;
            4'd13, 4'd10, 4'd7, 4'd4, 4'd1: c = 2'd1;
            default:                        c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/gsr_fifo.sv
module gsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
    localparam logic [CW-1:0] Full = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr, rd;

    assign o_full  = (r_count == Full);
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hw/rtl/gsr_front.sv
module gsr_front
    import gsr_pkg::*;
#(
    parameter int MAX_CHARS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_char_code,
    input  logic        i_first_char,
    input  logic [7:0]  i_start_x,
    input  logic [7:0]  i_start_y,
    input  logic [15:0] i_pixel_color,
    output logic        o_work_push,
    output t_work       o_work
);

    localparam int PW = $clog2(MAX_CHARS + 1);
    localparam logic [PW-1:0] MaxPos = PW'(MAX_CHARS);

    logic [7:0]    r_origin_col, r_origin_row;
    logic [PW-1:0] r_char_pos;
    logic [7:0]    n_origin_col, n_origin_row;
    logic [PW-1:0] n_char_pos;

    logic [7:0]           col, row;
    logic [PW-1:0]        pos;
    logic                 drop;
    logic [GlyphBits-1:0] bits;
    logic [XW-1:0]        pos_x;

    always_comb begin
        col   = i_first_char ? i_start_x : r_origin_col;
        row   = i_first_char ? i_start_y : r_origin_row;
        pos   = i_first_char ? '0 : r_char_pos;
        drop  = (pos >= MaxPos);
        bits  = glyph_bits(i_char_code);
        pos_x = XW'(pos) << 2;

        n_origin_col = r_origin_col;
        n_origin_row = r_origin_row;
        n_char_pos   = r_char_pos;
        if (i_accept) begin
            n_origin_col = col;
            n_origin_row = row;
            n_char_pos   = drop ? pos : pos + 1'b1;
        end

        o_work_push   = i_accept && !drop && (bits != '0);
        o_work.bits   = bits;
        o_work.base_x = {{(XW-8){col[7]}}, col} + pos_x;
        o_work.base_y = {{(YW-8){row[7]}}, row};
        o_work.color  = i_pixel_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_col <= '0;
            r_origin_row <= '0;
            r_char_pos   <= '0;
        end else begin
            r_origin_col <= n_origin_col;
            r_origin_row <= n_origin_row;
            r_char_pos   <= n_char_pos;
        end
    end

endmodule

### hw/rtl/gsr_back.sv
module gsr_back
    import gsr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_work_empty,
    input  t_work  i_work,
    output logic   o_work_pop,
    input  logic   i_pix_full,
    output logic   o_pix_push,
    output t_pixel o_pix
);

    logic                 r_busy;
    logic [GlyphBits-1:0] r_mask;
    t_work                r_work;
    logic                 n_busy;
    logic [GlyphBits-1:0] n_mask;

    logic [3:0]           hi_idx;
    logic [GlyphBits-1:0] rest;
    logic                 emit, last;

    always_comb begin
        hi_idx = '0;
        for (int i = 0; i < GlyphBits; i++) begin
            if (r_mask[i]) begin
                hi_idx = 4'(i);
            end
        end
        rest = r_mask & ~(GlyphBits'(1) << hi_idx);
        last = (rest == '0);
        emit = r_busy && !i_pix_full;

        o_pix_push  = emit;
        o_pix.x     = r_work.base_x + XW'(cell_col(hi_idx));
        o_pix.y     = r_work.base_y + YW'(cell_row(hi_idx));
        o_pix.color = r_work.color;
        o_pix.last  = last;

        o_work_pop = !i_work_empty && (!r_busy || (emit && last));

        n_busy = r_busy;
        n_mask = r_mask;
        if (o_work_pop) begin
            n_busy = 1'b1;
            n_mask = i_work.bits;
        end else if (emit) begin
            n_busy = !last;
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mask <= '0;
        end else begin
            r_busy <= n_busy;
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_work <= i_work;
        end
    end

endmodule

### hw/rtl/glyph_string_rasterizer_3x5.sv
// Draws strings in a 3x5 bitmap font, one character per item. An item with
// first_char set latches the origin and restarts the position; every later
// character sits 4 columns to the right. Digits, colon and hyphen produce one
// pixel per lit cell (up to 13), top row first, left to right, with
// last_pixel marking the final one. Other codes produce nothing but still
// advance; characters past MAX_CHARS are dropped. Items are taken one per
// cycle while the two-entry glyph queue has room; the pixel scanner then
// emits one pixel per cycle while the pixel queue has room. Digit 1 has 8
// lit cells, digit 8 has 13. An item's first pixel passes the glyph queue,
// the scanner registers and the pixel queue on its way to the result ports.
module glyph_string_rasterizer_3x5
    import gsr_pkg::*;
#(
    parameter int MAX_CHARS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_char_code,
    input  logic               i_first_char,
    input  logic signed [7:0]  i_start_x,
    input  logic signed [7:0]  i_start_y,
    input  logic [15:0]        i_pixel_color,
    output logic               empty,
    input  logic               pop,
    output logic signed [9:0]  o_pixel_x,
    output logic signed [8:0]  o_pixel_y,
    output logic [15:0]        o_color_out,
    output logic               o_last_pixel
);

    localparam int WorkDepth = 2;
    localparam int PixDepth  = 2;

    t_work  work_in, work_out;
    t_pixel pix_in, pix_out;
    logic   work_push, work_pop, work_full, work_empty;
    logic   pix_push, pix_full;

    assign full = work_full;

    gsr_front #(
        .MAX_CHARS(MAX_CHARS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push && !work_full),
        .i_char_code  (i_char_code),
        .i_first_char (i_first_char),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_pixel_color(i_pixel_color),
        .o_work_push  (work_push),
        .o_work       (work_in)
    );

    gsr_fifo #(
        .WIDTH($bits(t_work)),
        .DEPTH(WorkDepth)
    ) u_work_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (work_push),
        .i_data (work_in),
        .i_pop  (work_pop),
        .o_data (work_out),
        .o_full (work_full),
        .o_empty(work_empty)
    );

    gsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work_empty(work_empty),
        .i_work      (work_out),
        .o_work_pop  (work_pop),
        .i_pix_full  (pix_full),
        .o_pix_push  (pix_push),
        .o_pix       (pix_in)
    );

    gsr_fifo #(
        .WIDTH($bits(t_pixel)),
        .DEPTH(PixDepth)
    ) u_pix_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (pix_push),
        .i_data (pix_in),
        .i_pop  (pop),
        .o_data (pix_out),
        .o_full (pix_full),
        .o_empty(empty)
    );

    assign o_pixel_x    = pix_out.x;
    assign o_pixel_y    = pix_out.y;
    assign o_color_out  = pix_out.color;
    assign o_last_pixel = pix_out.last;

endmodule

### hw/rtl/gsr_checker.sv
module gsr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input logic signed [9:0] o_pixel_x,
    input logic signed [8:0] o_pixel_y,
    input logic [15:0]       o_color_out,
    input logic              o_last_pixel
);

    // nothing waits on either side straight after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue not clear after reset");

    // a character's pixels follow one another without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_last_pixel |=> !empty)
        else $error("gap inside a glyph");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting item withdrawn");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_pixel_x) && $stable(o_pixel_y)
                          && $stable(o_color_out) && $stable(o_last_pixel))
        else $error("waiting item changed");

endmodule

bind glyph_string_rasterizer_3x5 gsr_checker u_gsr_checker (.*);

### test/tb_top.sv
module tb_top;
    import gsr_pkg::*;

    localparam int MAX_CHARS = 64;
    localparam int LIMIT = 200000;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TOP = 8'hFF;
    localparam logic [14:0] FONT [12] = '{
        15'h7B6F, 15'h2C97, 15'h73E7, 15'h73CF, 15'h5BC9, 15'h79CF,
        15'h79EF, 15'h7292, 15'h7BEF, 15'h7BCF, 15'h0410, 15'h01C0
    };

    class pixel_scoreboard;
        t_pixel            expected_px[$];
        logic signed [7:0] org_x;
        logic signed [7:0] org_y;
        int unsigned       char_idx;
        int                errors;

        function new();
            org_x = '0;
            org_y = '0;
            char_idx = 0;
            errors = 0;
        endfunction

        function logic [14:0] font_word(logic [7:0] code);
            if (code >= CHAR_ZERO && code <= CHAR_NINE) return FONT[int'(code - CHAR_ZERO)];
            if (code == CHAR_COLON) return FONT[10];
            if (code == CHAR_HYPHEN) return FONT[11];
            return '0;
        endfunction

        // lit cells of one character, scanned from the top-left cell down
        function void note_char(logic [7:0] code, logic first, logic signed [7:0] sx,
                                logic signed [7:0] sy, logic [15:0] color);
            logic [14:0] g;
            t_pixel      p;
            int          bx;
            int          by;
            int          n;
            if (first) begin
                org_x = sx;
                org_y = sy;
                char_idx = 0;
            end
            if (char_idx >= MAX_CHARS) return;
            g = font_word(code);
            bx = int'(org_x) + 4 * int'(char_idx);
            by = int'(org_y);
            char_idx++;
            n = expected_px.size();
            for (int b = 14; b >= 0; b--) begin
                if (g[b]) begin
                    p.x = 10'(bx + (14 - b) % 3);
                    p.y = 9'(by + (14 - b) / 3);
                    p.color = color;
                    p.last = 1'b0;
                    expected_px.push_back(p);
                end
            end
            if (expected_px.size() > n) begin
                p = expected_px.pop_back();
                p.last = 1'b1;
                expected_px.push_back(p);
            end
        endfunction

        function void mismatch(string field, int exp_v, int act_v);
            errors++;
            if (errors <= 40) $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        endfunction

        function void check_pixel(logic signed [9:0] x, logic signed [8:0] y,
                                  logic [15:0] color, logic last);
            t_pixel p;
            if (expected_px.size() == 0) begin
                errors++;
                if (errors <= 40) $error("unexpected pixel x=%0d y=%0d", x, y);
                return;
            end
            p = expected_px.pop_front();
            if (p.x !== x) mismatch("pixel_x", $signed(p.x), x);
            if (p.y !== y) mismatch("pixel_y", $signed(p.y), y);
            if (p.color !== color) mismatch("color_out", p.color, color);
            if (p.last !== last) mismatch("last_pixel", p.last, last);
        endfunction

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_char_code = '0;
    logic        i_first_char = 1'b0;
    logic [7:0]  i_start_x = '0;
    logic [7:0]  i_start_y = '0;
    logic [15:0] i_pixel_color = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic signed [9:0] o_pixel_x;
    logic signed [8:0] o_pixel_y;
    logic [15:0] o_color_out;
    logic        o_last_pixel;

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  cycles = 0;
    logic hold_on = 1'b0;
    event hold_off;

    pixel_scoreboard sb = new;

    glyph_string_rasterizer_3x5 #(.MAX_CHARS(MAX_CHARS)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_char_code   (i_char_code),
        .i_first_char  (i_first_char),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_pixel_color (i_pixel_color),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_color_out   (o_color_out),
        .o_last_pixel  (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        wait (cycles >= LIMIT);
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && empty === 1'b0)
            sb.check_pixel(o_pixel_x, o_pixel_y, o_color_out, o_last_pixel);
        if (hold_on) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off so the glyph queue fills and full rises
    initial begin
        forever begin
            @(hold_off);
            hold_on <= 1'b1;
            repeat (400) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    task automatic send_char(input logic [7:0] code, input logic first, input logic [7:0] sx,
                             input logic [7:0] sy, input logic [15:0] color);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_char_code <= code;
        i_first_char <= first;
        i_start_x <= sx;
        i_start_y <= sy;
        i_pixel_color <= color;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_char(code, first, sx, sy, color);
    endtask

    function automatic logic [7:0] rand_code();
        int k;
        k = $urandom_range(99);
        if (k >= 85) return 8'($urandom);
        k = $urandom_range(11);
        if (k < 10) return CHAR_ZERO + 8'(k);
        return (k == 10) ? CHAR_COLON : CHAR_HYPHEN;
    endfunction

    task automatic send_strings(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_char(rand_code(), i == 0 || $urandom_range(99) < 5, 8'($urandom),
                          8'($urandom), 16'($urandom));
            sent += len;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no string started yet: origin stays at (0,0)
        send_char(CHAR_ZERO + 8'd8, 1'b0, 8'h55, 8'hAA, 16'hFFFF);
        send_char(CHAR_NUL, 1'b0, 8'h00, 8'h00, 16'h1234);
        send_char(CHAR_ZERO + 8'd1, 1'b1, 8'h80, 8'h80, 16'h0000);
        for (int i = 0; i < 10; i++)
            if (i != 1)
                send_char(CHAR_ZERO + 8'(i), 1'b0, 8'($urandom), 8'($urandom), 16'($urandom));
        send_char(CHAR_COLON, 1'b0, 8'h7F, 8'h7F, 16'hF800);
        send_char(CHAR_HYPHEN, 1'b0, 8'h00, 8'h00, 16'h07E0);
        send_char(CHAR_TOP, 1'b0, 8'hFF, 8'hFF, 16'h001F);
        send_char(CHAR_ZERO + 8'd8, 1'b1, 8'h7F, 8'h80, 16'hA5A5);
        send_char(CHAR_HYPHEN, 1'b1, 8'h80, 8'h7F, 16'h5A5A);
        send_char(CHAR_ZERO + 8'd8, 1'b1, 8'h7F, 8'h7F, 16'hFFFF);

        // string past MAX_CHARS, rightmost cell at the largest x the block can reach
        send_char(rand_code(), 1'b1, 8'h7F, 8'h7F, 16'($urandom));
        for (int i = 1; i < 70; i++)
            send_char(i == 63 ? CHAR_ZERO + 8'd8 : rand_code(), 1'b0, 8'($urandom),
                      8'($urandom), 16'($urandom));

        send_strings(16);
        idle_pct = 79;
        send_strings(16);
        idle_pct = 0;
        stall_pct = 79;
        send_strings(16);
        idle_pct = 14;
        stall_pct = 14;
        -> hold_off;
        send_strings(16);
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
